// File: design/cmi_pkg.sv
// Shared types and constants for the curve map interpolator.
package cmi_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ModeIdx = 0;
  localparam int unsigned CountIdx = 1;
  localparam logic [16:0] TOne = 17'h10000;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_READ,      // issue table read at address
    OP_LOAD_LO,   // capture x_lo, y_lo, m_lo from read data
    OP_LOAD_HI,   // capture x_hi, y_hi, m_hi from read data
    OP_DIV_INIT,  // set up t division
    OP_DIV_STEP,  // one quotient bit
    OP_MUL,       // one multiply step of the blend
    OP_OUT        // round, saturate, present result
  } dp_op_t;

  typedef struct packed {
    dp_op_t      op;
    logic [4:0]  step;
  } dp_cmd_t;

  typedef struct packed {
    logic q_le_lo;    // query at or below the x word just read
    logic q_gt_hi;    // query above the x word just read
    logic q_ge_hi;    // query at or above the x word just read
  } dp_stat_t;

endpackage

// File: design/cmi_ram.sv
// Generic single port RAM with registered read.
module cmi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/cmi_datapath.sv
// Datapath: point tables, segment registers, t divider and blend multiplier.
module cmi_datapath #(
  parameter int unsigned MaxPoints = 64
) (
  input  logic                         clk,
  input  cmi_pkg::dp_cmd_t             cmd,
  input  logic [$clog2(MaxPoints)-1:0] addr,
  input  logic                         we,
  input  logic                         cubic,
  input  logic signed [31:0]           wr_x,
  input  logic signed [31:0]           wr_y,
  input  logic signed [31:0]           wr_m,
  input  logic signed [31:0]           query,
  input  logic                         t_max,
  output cmi_pkg::dp_stat_t            stat,
  output logic signed [31:0]           result
);

  localparam logic [16:0] TOneC = cmi_pkg::TOne;

  logic signed [31:0] rd_x, rd_y, rd_m;
  logic signed [31:0] x_lo, x_hi, y_lo, y_hi, m_lo, m_hi;
  logic signed [32:0] dx, num;
  logic [32:0] rem;
  logic [16:0] t;
  logic [16:0] u;
  logic [35:0] h00, h01, h10, h11, wa, wb;
  logic signed [39:0] s_lo, s_hi;
  logic signed [87:0] acc;
  logic [33:0] rem_sh;
  logic signed [87:0] rnd;

  function automatic logic signed [87:0] rnd88(input logic signed [87:0] v,
                                               input int unsigned s);
    logic signed [87:0] w;
    begin
      w = v + (88'sd1 <<< (s - 1));
      rnd88 = w >>> s;
    end
  endfunction

  cmi_ram #(.Width(32), .Depth(MaxPoints)) u_xram (
    .clk(clk), .we(we), .addr(addr), .wdata(wr_x), .rdata(rd_x));
  cmi_ram #(.Width(32), .Depth(MaxPoints)) u_yram (
    .clk(clk), .we(we), .addr(addr), .wdata(wr_y), .rdata(rd_y));
  cmi_ram #(.Width(32), .Depth(MaxPoints)) u_mram (
    .clk(clk), .we(we), .addr(addr), .wdata(wr_m), .rdata(rd_m));

  assign stat.q_le_lo = query <= rd_x;
  assign stat.q_gt_hi = query > rd_x;
  assign stat.q_ge_hi = query >= rd_x;

  assign dx = 33'(x_hi) - 33'(x_lo);
  assign rem_sh = {rem, 1'b0};
  assign u = TOneC - t;
  assign rnd = rnd88(acc, 16);

  always_ff @(posedge clk) begin
    case (cmd.op)
      cmi_pkg::OP_LOAD_LO: begin
        x_lo <= rd_x; y_lo <= rd_y; m_lo <= rd_m;
      end
      cmi_pkg::OP_LOAD_HI: begin
        x_hi <= rd_x; y_hi <= rd_y; m_hi <= rd_m;
      end
      cmi_pkg::OP_DIV_INIT: begin
        num <= 33'(query) - 33'(x_lo);
        rem <= '0;
        t <= '0;
        acc <= '0;
      end
      cmi_pkg::OP_DIV_STEP: begin
        // restoring division of num<<16 by dx; step 0 checks the clamps, then one bit per step
        if (cmd.step == 5'd0) begin
          if (t_max) begin
            t <= TOneC;
          end else if (dx <= 0 || num < 0) begin
            t <= '0;
          end else if (num >= dx) begin
            t <= TOneC;
          end else begin
            rem <= num;
            t <= '0;
          end
        end else begin
          if (!(t_max || dx <= 0 || num < 0 || num >= dx)) begin
            if (rem_sh >= 34'(dx)) begin
              rem <= 33'(rem_sh - 34'(dx));
              t <= {t[15:0], 1'b1};
            end else begin
              rem <= rem_sh[32:0];
              t <= {t[15:0], 1'b0};
            end
          end
        end
      end
      cmi_pkg::OP_MUL: begin
        case (cmd.step)
          5'd0: begin
            wa <= 36'(u) * 36'(u);
            wb <= 36'(t) * 36'(t);
          end
          5'd1: begin
            h00 <= 36'(((72'(36'h10000 + 36'(t) * 2) * 72'(wa)) + 72'h80000000) >> 32);
            h01 <= 36'(((72'(36'h30000 - 36'(t) * 2) * 72'(wb)) + 72'h80000000) >> 32);
            h10 <= 36'(((72'(t) * 72'(wa)) + 72'h80000000) >> 32);
            h11 <= 36'(((72'(u) * 72'(wb)) + 72'h80000000) >> 32);
          end
          5'd2: begin
            s_lo <= 40'(rnd88((88'(signed'({1'b0, h10})) * 88'(dx)), 16));
            s_hi <= 40'(rnd88(-(88'(signed'({1'b0, h11})) * 88'(dx)), 16));
          end
          5'd3: begin
            if (cubic) begin
              acc <= 88'(signed'({1'b0, h00})) * 88'(y_lo);
            end else begin
              acc <= 88'(signed'({1'b0, u})) * 88'(y_lo);
            end
          end
          5'd4: begin
            if (cubic) begin
              acc <= acc + 88'(signed'({1'b0, h01})) * 88'(y_hi);
            end else begin
              acc <= acc + 88'(signed'({1'b0, t})) * 88'(y_hi);
            end
          end
          5'd5: begin
            if (cubic) acc <= acc + 88'(s_lo) * 88'(m_lo);
          end
          5'd6: begin
            if (cubic) acc <= acc + 88'(s_hi) * 88'(m_hi);
          end
          default: begin
          end
        endcase
      end
      cmi_pkg::OP_OUT: begin
        if (rnd > 88'sd2147483647) result <= 32'h7fffffff;
        else if (rnd < -88'sd2147483648) result <= 32'h80000000;
        else result <= rnd[31:0];
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/cmi_ctrl.sv
// Controller: sequences writes, clamp checks, segment walk, division and blend.
module cmi_ctrl #(
  parameter int unsigned MaxPoints = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         func,
  input  logic [5:0]                   point_index,
  input  logic [6:0]                   point_count,
  input  cmi_pkg::dp_stat_t            stat,
  output logic                         busy,
  output cmi_pkg::dp_cmd_t             cmd,
  output logic [$clog2(MaxPoints)-1:0] addr,
  output logic                         we,
  output logic                         t_max,
  output logic                         done
);

  localparam int unsigned AW = $clog2(MaxPoints);
  localparam logic [3:0] S_IDLE = 4'd0, S_RD0 = 4'd1, S_CHK0 = 4'd2,
    S_CHKN = 4'd3, S_WALK = 4'd4, S_WCHK = 4'd5, S_LO = 4'd6, S_LOW = 4'd7,
    S_HI = 4'd8, S_HIW = 4'd9, S_DIV = 4'd10, S_MUL = 4'd11, S_OUT = 4'd12,
    S_RDN = 4'd13;

  logic [3:0] state;
  logic [AW:0] n, k;
  logic [4:0] step;
  logic [AW:0] n_lim;

  always_comb begin
    if (point_count < 7'd2) n_lim = (AW+1)'(2);
    else if (32'(point_count) > MaxPoints) n_lim = (AW+1)'(MaxPoints);
    else n_lim = (AW+1)'(point_count);
  end

  assign busy = state != S_IDLE;

  always_comb begin
    cmd.op = cmi_pkg::OP_NONE;
    cmd.step = step;
    addr = k[AW-1:0];
    we = 1'b0;
    case (state)
      S_IDLE: begin
        addr = AW'(point_index);
        we = start && func && (32'(point_index) < MaxPoints);
      end
      S_LOW: cmd.op = cmi_pkg::OP_LOAD_LO;
      S_HIW: cmd.op = cmi_pkg::OP_LOAD_HI;
      S_DIV: cmd.op = (step == 5'd0 && k == '1) ? cmi_pkg::OP_DIV_INIT :
                      cmi_pkg::OP_DIV_STEP;
      S_MUL: cmd.op = cmi_pkg::OP_MUL;
      S_OUT: cmd.op = cmi_pkg::OP_OUT;
      default: cmd.op = cmi_pkg::OP_NONE;
    endcase
  end

  logic init_done;
  logic [AW:0] seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      step <= '0;
      init_done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && !func) begin
            n <= n_lim;
            k <= '0;
            state <= S_CHK0;
          end
        end
        S_CHK0: state <= S_RD0;
        S_RD0: begin
          if (stat.q_le_lo) begin
            seg <= '0; t_max <= 1'b0;
            state <= S_LO; k <= '0;
          end else begin
            k <= n - 1'b1; state <= S_RDN;
          end
        end
        S_RDN: state <= S_CHKN;
        S_CHKN: begin
          if (stat.q_ge_hi) begin
            seg <= n - 2'd2; t_max <= 1'b1;
            k <= n - 2'd2; state <= S_LO;
          end else begin
            t_max <= 1'b0; k <= (AW+1)'(1); state <= S_WALK;
          end
        end
        S_WALK: state <= S_WCHK;
        S_WCHK: begin
          // advance while query lies beyond the next point
          if (k + 1'b1 < n && stat.q_gt_hi) begin
            k <= k + 1'b1; state <= S_WALK;
          end else begin
            seg <= k - 1'b1; k <= k - 1'b1; state <= S_LO;
          end
        end
        S_LO: state <= S_LOW;
        S_LOW: begin k <= seg + 1'b1; state <= S_HI; end
        S_HI: state <= S_HIW;
        S_HIW: begin
          step <= '0; init_done <= 1'b0; k <= '1; state <= S_DIV;
        end
        S_DIV: begin
          if (!init_done) begin
            init_done <= 1'b1; k <= '0;
          end else if (step == 5'd16) begin
            step <= '0; state <= S_MUL;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_MUL: begin
          if (step == 5'd6) state <= S_OUT;
          else step <= step + 1'b1;
        end
        S_OUT: begin done <= 1'b1; state <= S_IDLE; step <= '0; end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/curve_map_interpolator_top.sv
// Top level of the curve map interpolator.
// Usage:
//   Pulse start with func=1 to store one control point (point_index,
//   point_x, point_y, point_slope); the table write completes in the
//   accepting cycle, busy stays low and no word is returned.
//   Pulse start with func=0 to map query_x. busy stays high while the
//   query runs; the result word appears on mapped_value with valid high for
//   one cycle, in the same cycle that busy falls. The receiver cannot stall.
//   Busy time per query is shortest when query_x is at or below the first x,
//   longer when at or above the last x, and longer still when the segment
//   walk runs, growing with each point read (up to point_count-1 reads).
//   The fixed part is set by a t divider (setup plus 16 quotient bits) and
//   a 7-step blend. The next word is taken while valid is high.
//   Configuration: cfg_valid/cfg_ready with cfg_index, cfg_data; index 0 is
//   cubic_mode, index 1 is point_count. Write only while idle.
//   Reset (rst, synchronous) returns the block idle with linear mode and two
//   points; table contents are undefined until written.
module curve_map_interpolator_top #(
  parameter int unsigned MaxPoints = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic [5:0]         point_index,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_slope,
  input  logic signed [31:0] query_x,
  output logic               valid,
  output logic signed [31:0] mapped_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic cubic_mode;
  logic [6:0] point_count;
  logic signed [31:0] query;
  cmi_pkg::dp_cmd_t cmd;
  cmi_pkg::dp_stat_t stat;
  logic [$clog2(MaxPoints)-1:0] addr;
  logic we, t_max;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cubic_mode <= 1'b0;
      point_count <= 7'd2;
    end else if (cfg_valid) begin
      if (cfg_index == 1'(cmi_pkg::ModeIdx)) cubic_mode <= cfg_data[0];
      else point_count <= cfg_data[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) query <= query_x;
  end

  cmi_ctrl #(.MaxPoints(MaxPoints)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .func(func),
    .point_index(point_index), .point_count(point_count), .stat(stat),
    .busy(busy), .cmd(cmd), .addr(addr), .we(we), .t_max(t_max), .done(valid));

  cmi_datapath #(.MaxPoints(MaxPoints)) u_dp (
    .clk(clk), .cmd(cmd), .addr(addr), .we(we), .cubic(cubic_mode),
    .wr_x(point_x), .wr_y(point_y), .wr_m(point_slope), .query(query),
    .t_max(t_max), .stat(stat), .result(mapped_value));

endmodule

// File: dv/tb_curve_map_interpolator_top.sv
// Self-checking testbench for the curve map interpolator: directed rows, then random tables.
`timescale 1ns / 100ps

module tb_curve_map_interpolator_top;

  localparam int TablePoints = 64;
  localparam int StallLimit = 6000;
  localparam int DrainCycles = 200;

  typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [5:0]  idx;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pm;
    logic [31:0] q;
    logic        chk;
    logic [31:0] want;
  } row_t;

  logic clk, rst, start, busy, func, valid, cfg_valid, cfg_ready;
  logic [5:0] point_index;
  logic signed [31:0] point_x, point_y, point_slope, query_x, mapped_value;
  logic [0:0] cfg_index;
  logic [31:0] cfg_data;

  // Shadow of the block's state
  logic signed [31:0] sh_x[TablePoints];
  logic signed [31:0] sh_y[TablePoints];
  logic signed [31:0] sh_m[TablePoints];
  logic cur_cubic;
  logic [6:0] cur_count;

  logic [31:0] pending_values[$];
  int errors;
  int stall_cnt;
  int items;
  row_t dir_rows[21];

  curve_map_interpolator_top dut (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint rnd32_unsigned(longint unsigned p);
    return longint'((p + 64'h8000_0000) >> 32);
  endfunction

  function automatic logic [31:0] map_query(longint q);
    int n, k;
    longint unsigned t, u;
    longint dx, num, acc, r, h00, h01, h10, h11;
    n = cur_count;
    k = 0;
    dx = 0;
    if (n < 2) n = 2;
    if (n > TablePoints) n = TablePoints;
    if (q <= longint'(sh_x[0])) begin
      t = 0;
    end else if (q >= longint'(sh_x[n-1])) begin
      k = n - 2;
      t = 65536;
    end else begin
      while (k + 2 < n && q > longint'(sh_x[k+1])) k++;
      dx = longint'(sh_x[k+1]) - longint'(sh_x[k]);
      num = q - longint'(sh_x[k]);
      if (dx <= 0 || num < 0) t = 0;
      else if (num >= dx) t = 65536;
      else t = (longint'(num) << 16) / dx;
    end
    u = 65536 - t;
    if (cur_cubic) begin
      h00 = rnd32_unsigned((65536 + 2 * t) * u * u);
      h01 = rnd32_unsigned((196608 - 2 * t) * t * t);
      h10 = rnd32_unsigned(t * u * u);
      h11 = -rnd32_unsigned(u * t * t);
      acc = h00 * longint'(sh_y[k]) + h01 * longint'(sh_y[k+1])
          + rnd_shift(h10 * dx, 16) * longint'(sh_m[k])
          + rnd_shift(h11 * dx, 16) * longint'(sh_m[k+1]);
    end else begin
      acc = longint'(u) * longint'(sh_y[k]) + longint'(t) * longint'(sh_y[k+1]);
    end
    r = rnd_shift(acc, 16);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // Append one expected word behind the ones still outstanding.
  task automatic queue_expected(input logic [31:0] word);
    pending_values = {pending_values, word};
  endtask

  // Drive one word; writes update the shadow, queries queue a prediction.
  task automatic send_item(input logic f, input logic [5:0] idx, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] pm,
                           input logic [31:0] q, input logic chk, input logic [31:0] want);
    int gap;
    logic [31:0] pred;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    func = f;
    point_index = idx;
    point_x = px;
    point_y = py;
    point_slope = pm;
    query_x = q;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if (f) begin
      sh_x[idx] = px;
      sh_y[idx] = py;
      sh_m[idx] = pm;
    end else begin
      pred = map_query(longint'($signed(q)));
      if (chk && pred !== want) begin
        errors++;
        if (errors <= 10)
          $display("table row disagrees: q=%h typed %h computed %h", q, want, pred);
      end
      queue_expected(chk ? want : pred);
    end
    items++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] ridx, input logic [31:0] data);
    start = 1'b0;
    @(negedge clk);
    while (pending_values.size() != 0 || busy) @(negedge clk);
    // hold off until any trailing work has surely drained
    repeat (170) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = ridx;
    cfg_data = data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (ridx == 1'(cmi_pkg::ModeIdx)) cur_cubic = data[0];
    else cur_count = data[6:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    if ($urandom_range(0, 1)) return $urandom();
    return 32'($signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000);
  endfunction

  // Monitor: compare each result word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && valid) begin
      if (pending_values.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", mapped_value);
      end else begin
        if (mapped_value !== pending_values[0]) begin
          errors++;
          if (errors <= 10)
            $display("mapped_value mismatch: expected %h got %h",
                     pending_values[0], mapped_value);
        end
        void'(pending_values.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || valid || (cfg_valid && cfg_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("curve_map_interpolator_top regression: fail");
      $finish;
    end
  end

  initial begin
    int n_eff, nq, sel, cnt;
    longint span, base, step, lo, hi, xv;
    logic [6:0] cnt_field;
    rst = 1'b1;
    start = 1'b0;
    func = 1'b0;
    point_index = '0;
    point_x = '0;
    point_y = '0;
    point_slope = '0;
    query_x = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    stall_cnt = 0;
    items = 0;
    cur_cubic = 1'b0;
    cur_count = 7'd2;
    for (int i = 0; i < TablePoints; i++) begin
      sh_x[i] = '0;
      sh_y[i] = '0;
      sh_m[i] = '0;
    end

    dir_rows = '{
      '{ROW_WRITE, 6'd0, 32'hFFFF0000, 32'h80000000, 32'h7FFFFFFF, 32'h0, 1'b0, 32'h0},
      '{ROW_WRITE, 6'd1, 32'h00010000, 32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b0, 32'h0},
      '{ROW_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h80000000, 1'b1, 32'h80000000},
      '{ROW_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF},
      '{ROW_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'hFFFF0000, 1'b1, 32'h80000000},
      '{ROW_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h00000000, 1'b0, 32'h0},
      '{ROW_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h00008000, 1'b0, 32'h0},
      '{ROW_WRITE, 6'd63, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFF, 1'b0, 32'h0},
      '{ROW_WRITE, 6'd62, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 1'b0, 32'h0},
      '{ROW_CFG, 6'(cmi_pkg::ModeIdx), 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_CFG, 6'(cmi_pkg::CountIdx), 32'h00000001, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h00000000, 1'b0, 32'h0},
      '{ROW_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h00004000, 1'b0, 32'h0},
      '{ROW_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h80000000, 1'b1, 32'h80000000},
      // zero-width segment: anything above the first x clamps to the last y
      '{ROW_WRITE, 6'd1, 32'hFFFF0000, 32'h12345678, 32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h00000000, 1'b1, 32'h12345678},
      '{ROW_WRITE, 6'd1, 32'h00020000, 32'h00010000, 32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_CFG, 6'(cmi_pkg::CountIdx), 32'hFFFFFF82, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h00010000, 1'b0, 32'h0},
      '{ROW_CFG, 6'(cmi_pkg::ModeIdx), 32'hFFFFFFFE, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h00010000, 1'b0, 32'h0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_WRITE: begin
          send_item(1'b1, dir_rows[i].idx, dir_rows[i].px, dir_rows[i].py, dir_rows[i].pm,
                    dir_rows[i].q, 1'b0, 32'h0);
        end
        ROW_QUERY: begin
          send_item(1'b0, 6'($urandom()), $urandom(), $urandom(), $urandom(),
                    dir_rows[i].q, dir_rows[i].chk, dir_rows[i].want);
        end
        default: begin
          write_reg(dir_rows[i].idx[0], dir_rows[i].px);
        end
      endcase
    end

    cnt = 0;
    while (items < 1600) begin
      // pick a point count, extremes included
      sel = $urandom_range(0, 99);
      if (cnt == 0 || sel < 10) cnt_field = 7'd64;
      else if (sel < 15) cnt_field = 7'($urandom_range(0, 1));
      else if (sel < 20) cnt_field = 7'($urandom_range(65, 127));
      else if (sel < 75) cnt_field = 7'($urandom_range(2, 8));
      else cnt_field = 7'($urandom_range(9, 63));
      n_eff = cnt_field < 2 ? 2 : (cnt_field > TablePoints ? TablePoints : cnt_field);
      write_reg(1'(cmi_pkg::ModeIdx), $urandom());
      write_reg(1'(cmi_pkg::CountIdx), {25'($urandom()), cnt_field});
      cnt++;

      // mostly sorted x positions over a random span, with occasional random outliers
      span = ($urandom_range(0, 2) == 0) ? longint'($urandom()) :
             longint'($urandom_range(n_eff, 32'h0100_0000));
      if (span < n_eff) span = n_eff;
      base = -64'sd2147483648 + longint'($urandom()) % (64'sd4294967296 - span);
      step = span / (n_eff - 1);
      for (int i = 0; i < n_eff; i++) begin
        xv = base + step * i;
        if (i > 0 && $urandom_range(0, 3) == 0) xv = xv - longint'($urandom_range(0, 32'(step)));
        if ($urandom_range(0, 19) == 0) xv = longint'($signed($urandom()));
        send_item(1'b1, 6'(i), xv[31:0], rand_value(), rand_value(), $urandom(), 1'b0, 32'h0);
      end
      lo = base;
      hi = base + step * (n_eff - 1);

      nq = $urandom_range(10, 40);
      for (int j = 0; j < nq; j++) begin
        sel = $urandom_range(0, 99);
        if (sel < 75) xv = lo + longint'(($urandom() * longint'(hi - lo + 1)) >> 32);
        else if (sel < 85) xv = longint'(sh_x[$urandom_range(0, n_eff - 1)]);
        else if (sel < 92) begin
          xv = longint'($signed($urandom()));
        end else begin
          // noise write anywhere in the table
          send_item(1'b1, 6'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                    1'b0, 32'h0);
          continue;
        end
        send_item(1'b0, 6'($urandom()), $urandom(), $urandom(), $urandom(), xv[31:0],
                  1'b0, 32'h0);
      end
    end

    start = 1'b0;
    while (pending_values.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (errors == 0 && pending_values.size() == 0) begin
      $display("curve_map_interpolator_top regression: pass");
    end else begin
      $display("curve_map_interpolator_top regression: fail");
    end
    $finish;
  end

endmodule
